// ===== rtl/core/four_lane_led_pixel_serializer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the four-lane LED pixel serializer
// Shared wrappers so that every concurrent check is written the same way.
// ----------------------------------------------------------------------------
`ifndef FOUR_LANE_LED_PIXEL_SERIALIZER_MACROS_SVH
`define FOUR_LANE_LED_PIXEL_SERIALIZER_MACROS_SVH

// Check that is switched off while reset is asserted.
`define FLPS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds while reset is asserted.
`define FLPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/flps_pkg.sv =====
// ----------------------------------------------------------------------------
// flps_pkg
// Types and constants shared by the LED pixel serializer modules.
// ----------------------------------------------------------------------------
package flps_pkg;

  // Number of lanes driven in lockstep, fixed by the byte ports.
  localparam int unsigned Lanes = 4;
  // Bits sent per lane byte.
  localparam int unsigned ByteBits = 8;
  localparam int unsigned BitsLeftW = 4;

  localparam int unsigned SlotCfgW = 10;
  localparam int unsigned LatchCfgW = 16;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgZeroHigh = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOneHigh  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBitPeriod = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgLatch    = 2'd3;

  // Reset values of the timing registers.
  localparam logic [SlotCfgW-1:0]  ZeroHighReset  = 10'd29;
  localparam logic [SlotCfgW-1:0]  OneHighReset   = 10'd58;
  localparam logic [SlotCfgW-1:0]  BitPeriodReset = 10'd120;
  localparam logic [LatchCfgW-1:0] LatchReset     = 16'd960;

  // Item operation codes.
  localparam logic OpTick = 1'b0;
  localparam logic OpLoad = 1'b1;

  // Sequencer phase, one-hot.
  typedef enum logic [2:0] {
    PhIdle  = 3'b001,
    PhSend  = 3'b010,
    PhLatch = 3'b100
  } phase_e;

  // Timing configuration as seen by the engine.
  typedef struct packed {
    logic [SlotCfgW-1:0]  zero_high;
    logic [SlotCfgW-1:0]  one_high;
    logic [SlotCfgW-1:0]  bit_period;
    logic [LatchCfgW-1:0] latch;
  } timing_cfg_t;

  // One result item.
  typedef struct packed {
    logic [Lanes-1:0] line_levels;
    logic             load_accepted;
    logic             busy;
  } result_t;

endpackage

// ===== rtl/core/flps_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// flps_cfg_regs
// Timing configuration registers written through a plain write port.
// ----------------------------------------------------------------------------
module flps_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [flps_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [flps_pkg::CfgDataW-1:0]     cfg_data_i,
  output flps_pkg::timing_cfg_t             cfg_o
);

  flps_pkg::timing_cfg_t cfg_q;
  flps_pkg::timing_cfg_t cfg_d;

  // Decode the write into the addressed register.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        flps_pkg::CfgZeroHigh:  cfg_d.zero_high  = cfg_data_i[flps_pkg::SlotCfgW-1:0];
        flps_pkg::CfgOneHigh:   cfg_d.one_high   = cfg_data_i[flps_pkg::SlotCfgW-1:0];
        flps_pkg::CfgBitPeriod: cfg_d.bit_period = cfg_data_i[flps_pkg::SlotCfgW-1:0];
        flps_pkg::CfgLatch:     cfg_d.latch      = cfg_data_i[flps_pkg::LatchCfgW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zero_high  <= flps_pkg::ZeroHighReset;
      cfg_q.one_high   <= flps_pkg::OneHighReset;
      cfg_q.bit_period <= flps_pkg::BitPeriodReset;
      cfg_q.latch      <= flps_pkg::LatchReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/flps_engine.sv =====
// ----------------------------------------------------------------------------
// flps_engine
// Serializer state and the single-pass update for one item.
// ----------------------------------------------------------------------------
module flps_engine #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic                        operation_i,
  input  logic [flps_pkg::ByteBits-1:0] lane_bytes_i [flps_pkg::Lanes],
  input  logic                        frame_end_i,
  input  flps_pkg::timing_cfg_t       cfg_i,
  output flps_pkg::result_t           result_o
);

  // Compare width covers both the timer and the widest setting.
  localparam int unsigned CmpW =
    (TIMER_BITS > flps_pkg::LatchCfgW) ? TIMER_BITS : flps_pkg::LatchCfgW;

  logic [flps_pkg::ByteBits-1:0]  shift_q [flps_pkg::Lanes];
  logic [flps_pkg::ByteBits-1:0]  shift_d [flps_pkg::Lanes];
  logic [flps_pkg::BitsLeftW-1:0] bits_q, bits_d;
  logic [TIMER_BITS-1:0]          timer_q, timer_d;
  flps_pkg::phase_e               phase_q, phase_d;
  logic                           closing_q, closing_d;
  logic [flps_pkg::Lanes-1:0]     line_q, line_d;

  logic [TIMER_BITS-1:0]          timer_inc;
  logic [CmpW-1:0]                timer_ext, next_ext;
  logic [CmpW-1:0]                zero_ext, one_ext, period_ext, latch_ext;
  logic                           timer_full;
  logic [flps_pkg::Lanes-1:0]     lane_high;
  logic                           accepted;
  logic                           is_send, is_latch;

  assign timer_inc  = timer_q + 1'b1;
  assign timer_full = &timer_q;
  assign timer_ext  = CmpW'(timer_q);
  assign next_ext   = CmpW'(timer_inc);
  assign zero_ext   = CmpW'(cfg_i.zero_high);
  assign one_ext    = CmpW'(cfg_i.one_high);
  assign period_ext = CmpW'(cfg_i.bit_period);
  assign latch_ext  = CmpW'(cfg_i.latch);

  // Undefined phase codes behave as idle.
  always_comb begin
    is_send  = 1'b0;
    is_latch = 1'b0;
    case (phase_q)
      flps_pkg::PhSend:  is_send  = 1'b1;
      flps_pkg::PhLatch: is_latch = 1'b1;
      default: begin
        is_send  = 1'b0;
        is_latch = 1'b0;
      end
    endcase
  end

  // Per-lane level in the current slot: ones hold until one-high, zeros
  // drop at zero-high, and nothing stays up past one-high.
  always_comb begin
    for (int i = 0; i < flps_pkg::Lanes; i++) begin
      lane_high[i] = (timer_ext < one_ext) &&
                     (shift_q[i][flps_pkg::ByteBits-1] || (timer_ext < zero_ext));
    end
  end

  // Next state for the item in the input register.
  always_comb begin
    shift_d   = shift_q;
    bits_d    = bits_q;
    timer_d   = timer_q;
    phase_d   = (is_send || is_latch) ? phase_q : flps_pkg::PhIdle;
    closing_d = closing_q;
    line_d    = line_q;
    accepted  = 1'b0;

    if (operation_i == flps_pkg::OpLoad) begin
      // A load is taken only when idle; otherwise it changes nothing.
      if (!is_send && !is_latch) begin
        shift_d   = lane_bytes_i;
        bits_d    = flps_pkg::BitsLeftW'(flps_pkg::ByteBits);
        timer_d   = '0;
        closing_d = frame_end_i;
        line_d    = '0;
        phase_d   = flps_pkg::PhSend;
        accepted  = 1'b1;
      end
    end else if (is_send) begin
      line_d = lane_high;
      if (next_ext >= period_ext || timer_full) begin
        timer_d = '0;
        for (int i = 0; i < flps_pkg::Lanes; i++) begin
          shift_d[i] = {shift_q[i][flps_pkg::ByteBits-2:0], 1'b0};
        end
        bits_d = bits_q - 1'b1;
        if (bits_d == '0) begin
          phase_d = closing_q ? flps_pkg::PhLatch : flps_pkg::PhIdle;
        end
      end else begin
        timer_d = timer_inc;
      end
    end else if (is_latch) begin
      line_d = '0;
      if (next_ext >= latch_ext || timer_full) begin
        timer_d   = '0;
        phase_d   = flps_pkg::PhIdle;
        closing_d = 1'b0;
      end else begin
        timer_d = timer_inc;
      end
    end else begin
      line_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < flps_pkg::Lanes; i++) begin
        shift_q[i] <= '0;
      end
      bits_q    <= '0;
      timer_q   <= '0;
      phase_q   <= flps_pkg::PhIdle;
      closing_q <= 1'b0;
      line_q    <= '0;
    end else if (step_i) begin
      shift_q   <= shift_d;
      bits_q    <= bits_d;
      timer_q   <= timer_d;
      phase_q   <= phase_d;
      closing_q <= closing_d;
      line_q    <= line_d;
    end
  end

  // Result reflects the state after this item.
  assign result_o.line_levels   = line_d;
  assign result_o.load_accepted = accepted;
  assign result_o.busy          = (phase_d == flps_pkg::PhSend) ||
                                  (phase_d == flps_pkg::PhLatch);

endmodule

// ===== rtl/core/four_lane_led_pixel_serializer.sv =====
// ----------------------------------------------------------------------------
// four_lane_led_pixel_serializer
// Drives four one-wire LED pixel lines in lockstep from per-lane bytes.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the input channel (in_valid_i / in_stall_o). A tick item
// advances the waveform timebase by one tick; a load item hands over one
// byte per lane, sent most significant bit first, and is refused while the
// block is busy. Every item, tick or load, produces exactly one result on the
// output channel (out_valid_o / out_stall_i) with the lane levels, whether a
// load was taken, and the busy flag.
// An item is held in the input register and its result is registered in the
// output register. One item is accepted every cycle unless the output side
// stalls; the update for an item is a single compare-and-select pass over the
// serializer state. When the receiver stalls, the result register holds and
// the input register fills; after that in_stall_o rises in the same cycle as
// out_stall_i. Reset clears both valid bits and the engine's line state, sets
// the sequencer idle and the timing registers to their default values.
// Timing registers are written through cfg_we_i / cfg_idx_i / cfg_data_i;
// the user must write them only while no item is in flight (not enforced).
// ----------------------------------------------------------------------------
module four_lane_led_pixel_serializer #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [flps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [flps_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic [7:0]                    lane0_byte_i,
  input  logic [7:0]                    lane1_byte_i,
  input  logic [7:0]                    lane2_byte_i,
  input  logic [7:0]                    lane3_byte_i,
  input  logic                          frame_end_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [3:0]                    line_levels_o,
  output logic                          load_accepted_o,
  output logic                          busy_res_o
);

  flps_pkg::timing_cfg_t          cfg;
  flps_pkg::result_t              result;
  logic                           in_valid_q;
  logic                           op_q;
  logic [flps_pkg::ByteBits-1:0]  bytes_q [flps_pkg::Lanes];
  logic                           frame_end_q;
  logic                           out_valid_q;
  flps_pkg::result_t              out_q;
  logic                           advance;
  logic                           in_take;
  logic                           step;

  // Pipeline moves whenever the result register is free or being drained.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;
  assign step       = in_valid_q && advance;

  flps_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Input register: valid is control, the fields are payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (advance || !in_valid_q) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q        <= operation_i;
      bytes_q[0]  <= lane0_byte_i;
      bytes_q[1]  <= lane1_byte_i;
      bytes_q[2]  <= lane2_byte_i;
      bytes_q[3]  <= lane3_byte_i;
      frame_end_q <= frame_end_i;
    end
  end

  flps_engine #(
    .TIMER_BITS (TIMER_BITS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .operation_i  (op_q),
    .lane_bytes_i (bytes_q),
    .frame_end_i  (frame_end_q),
    .cfg_i        (cfg),
    .result_o     (result)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign line_levels_o   = out_q.line_levels;
  assign load_accepted_o = out_q.load_accepted;
  assign busy_res_o      = out_q.busy;

endmodule

// ===== rtl/core/flps_port_monitor.sv =====
// ----------------------------------------------------------------------------
// flps_port_monitor
// Port-level checks on the serializer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "four_lane_led_pixel_serializer_macros.svh"

module flps_port_monitor (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [3:0] line_levels_o,
  input logic       load_accepted_o,
  input logic       busy_res_o
);

  // A stalled result stays put.
  `FLPS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(line_levels_o) && $stable(load_accepted_o) && $stable(busy_res_o), "stalled result changed")

  // A taken load starts sending with all lines still low.
  `FLPS_ASSERT(a_load_busy, clk_i, rst_ni, out_valid_o && load_accepted_o |-> busy_res_o && (line_levels_o == 4'h0), "accepted load not busy or lines high")

  // The input side only stalls when the output side does.
  `FLPS_ASSERT(a_stall_cause, clk_i, rst_ni, !out_stall_i |-> !in_stall_o, "input stalled without output stall")

  // No result comes out of reset.
  `FLPS_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o, "result valid right after reset")

endmodule

bind four_lane_led_pixel_serializer flps_port_monitor u_port_monitor (.*);
